[design/tisa_pkg.sv]
package tisa_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_THRUST      = 3'd0;
	localparam logic [2:0] REG_MAX_THRUST      = 3'd1;
	localparam logic [2:0] REG_IGNITION_TICKS  = 3'd2;
	localparam logic [2:0] REG_RAMP_UP_STEP    = 3'd3;
	localparam logic [2:0] REG_RAMP_DOWN_STEP  = 3'd4;
	localparam logic [2:0] REG_MAX_DEFLECTION  = 3'd5;
	localparam logic [2:0] REG_DEFLECTION_STEP = 3'd6;

	// full scale of throttle (Q0.16) and of the gimbal command (Q1.15)
	localparam logic [16:0] THROTTLE_FULL = 17'd65535;
	localparam logic [15:0] STEER_FULL    = 16'd32767;

	typedef struct packed {
		logic [15:0] min_thrust;
		logic [15:0] max_thrust;
		logic [15:0] ignition_ticks;
		logic [15:0] ramp_up_step;
		logic [15:0] ramp_down_step;
		logic [14:0] max_deflection;
		logic [15:0] deflection_step;
	} tisa_cfg_t;

	typedef struct packed {
		logic        lit;
		logic [15:0] ign_cnt;
		logic [15:0] thrust;
		logic [15:0] nozzle;
	} tisa_state_t;

	// products of one tick, taken at the input register
	typedef struct packed {
		logic [31:0] thr_prod;
		logic [29:0] noz_prod;
		logic        steer_neg;
	} tisa_prod_t;

	// slew value toward target by at most step, zero step jumps at once
	function automatic logic signed [17:0] move_toward(
		input logic signed [17:0] value,
		input logic signed [17:0] target,
		input logic [15:0]        step
	);
		logic signed [17:0] s;
		logic signed [17:0] up;
		logic signed [17:0] dn;
		s  = signed'({2'b00, step});
		up = value + s;
		dn = value - s;
		if (step == 16'd0)
			return target;
		else if (target > value)
			return (up < target) ? up : target;
		else
			return (dn > target) ? dn : target;
	endfunction

endpackage

[design/thruster_ignition_slew_actuator.sv]
// Thruster ignition and slew actuator: each input item is one control tick
// (throttle in s_tdata[15:0], gimbal command in s_tdata[31:16]) and yields
// exactly one result item with thrust, nozzle angle and the burning flag.
// The block takes a new item every cycle while the result register can drain
// (m_tready high or no result held). An item passes the input register,
// which holds the two products, then the result register, which holds the
// updated tick state and result. The thruster state lives in registers that
// update as each item enters the result register, so ticks chain back to
// back. Configuration writes (cfg_index 0..6, data in cfg_data) are always
// accepted and must only be issued while no items are in flight.
module thruster_ignition_slew_actuator
	import tisa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // throttle [15:0], steer_command [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // thrust_out [15:0], nozzle_out [31:16],
	                               // burning [32], zero [39:33]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tisa_cfg_t   cfg_q;
	tisa_state_t st_q;
	tisa_state_t st_nxt;
	tisa_prod_t  prod_s1;
	tisa_prod_t  prod_in;
	logic        v_s1;
	logic        v_s2;
	logic        adv_s2;
	logic [39:0] data_s2;
	logic signed [15:0] steer_in;
	logic [14:0] steer_abs;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_thrust      <= 16'd0;
			cfg_q.max_thrust      <= 16'hFFFF;
			cfg_q.ignition_ticks  <= 16'd0;
			cfg_q.ramp_up_step    <= 16'd0;
			cfg_q.ramp_down_step  <= 16'd0;
			cfg_q.max_deflection  <= 15'd0;
			cfg_q.deflection_step <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_THRUST:      cfg_q.min_thrust      <= cfg_data;
				REG_MAX_THRUST:      cfg_q.max_thrust      <= cfg_data;
				REG_IGNITION_TICKS:  cfg_q.ignition_ticks  <= cfg_data;
				REG_RAMP_UP_STEP:    cfg_q.ramp_up_step    <= cfg_data;
				REG_RAMP_DOWN_STEP:  cfg_q.ramp_down_step  <= cfg_data;
				REG_MAX_DEFLECTION:  cfg_q.max_deflection  <= cfg_data[14:0];
				REG_DEFLECTION_STEP: cfg_q.deflection_step <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: result register drains, input stage follows
	assign adv_s2   = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv_s2;

	// multiplies at the input, clamping the most negative command
	assign steer_in  = signed'(s_tdata[31:16]);
	assign steer_abs = (steer_in == -16'sd32768) ? 15'h7FFF :
		(steer_in[15] ? 15'(-steer_in) : steer_in[14:0]);
	assign prod_in.thr_prod  = 32'(s_tdata[15:0]) * 32'(cfg_q.max_thrust);
	assign prod_in.noz_prod  = 30'(steer_abs) * 30'(cfg_q.max_deflection);
	assign prod_in.steer_neg = steer_in[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			prod_s1 <= prod_in;
		end
	end

	// per-tick state update
	tisa_step u_step (
		.cfg  (cfg_q),
		.prod (prod_s1),
		.cur  (st_q),
		.nxt  (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			data_s2 <= {7'd0, st_nxt.lit, st_nxt.nozzle, st_nxt.thrust};
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = data_s2;

`ifndef SYNTHESIS
	// a lit thruster never has a countdown pending
	a_lit_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.lit |-> st_q.ign_cnt == 16'd0)
		else $error("countdown pending while lit");

	// while counting down to ignition, thrust stays at zero
	a_count_at_rest: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ign_cnt != 16'd0 |-> st_q.thrust == 16'd0)
		else $error("thrust nonzero during ignition countdown");

	// a new result carries the updated burning state and thrust
	a_burning_match: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && v_s1) |=> (m_tdata[32] == st_q.lit && m_tdata[15:0] == st_q.thrust))
		else $error("result does not match thruster state");

	// result valid only after an item passed the input stage
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && !v_s1) |=> !m_tvalid)
		else $error("result without item");
`endif

endmodule

[design/tisa_step.sv]
module tisa_step
	import tisa_pkg::*;
(
	input  tisa_cfg_t   cfg,
	input  tisa_prod_t  prod,
	input  tisa_state_t cur,
	output tisa_state_t nxt
);

	logic [16:0] thr_q0;
	logic [16:0] thr_rem;
	logic [15:0] asked;
	logic [15:0] demand;
	logic [15:0] raised;
	logic [14:0] noz_q0;
	logic [15:0] noz_rem;
	logic [14:0] mag;
	logic signed [17:0] commanded;
	logic [15:0] cd_load;
	logic        lit_now;
	logic [15:0] thr_lit;
	logic [15:0] floor_v;
	logic [17:0] slew_up;
	logic [17:0] slew_dn;
	logic [17:0] slew_noz;

	// throttle * max_thrust / 65535 with one correction step
	assign thr_q0  = {1'b0, prod.thr_prod[31:16]};
	assign thr_rem = {1'b0, prod.thr_prod[15:0]} + thr_q0;
	assign asked   = (thr_rem >= THROTTLE_FULL) ? 16'(thr_q0 + 17'd1) : thr_q0[15:0];

	// demand: off below half of the floor, else clamp to floor then ceiling
	assign raised = (asked < cfg.min_thrust) ? cfg.min_thrust : asked;
	always_comb begin
		if ({asked, 1'b0} < {1'b0, cfg.min_thrust})
			demand = 16'd0;
		else if (raised > cfg.max_thrust)
			demand = cfg.max_thrust;
		else
			demand = raised;
	end

	// |command| * max_deflection / 32767 with one correction step
	assign noz_q0  = prod.noz_prod[29:15];
	assign noz_rem = {1'b0, prod.noz_prod[14:0]} + {1'b0, noz_q0};
	assign mag     = (noz_rem >= STEER_FULL) ? 15'(noz_q0 + 15'd1) : noz_q0;
	assign commanded = prod.steer_neg ? -signed'({3'b000, mag}) : signed'({3'b000, mag});

	// ignition countdown, loaded only from rest
	assign cd_load = (cur.ign_cnt == 16'd0 && cur.thrust == 16'd0) ?
		cfg.ignition_ticks : cur.ign_cnt;
	assign lit_now = cur.lit || (cd_load <= 16'd1);
	assign thr_lit = (!cur.lit && cur.thrust < cfg.min_thrust) ? cfg.min_thrust : cur.thrust;
	assign floor_v = (cfg.min_thrust < demand) ? cfg.min_thrust : demand;

	assign slew_up = move_toward(signed'({2'b00, thr_lit}), signed'({2'b00, demand}),
		cfg.ramp_up_step);
	assign slew_dn = move_toward(signed'({2'b00, cur.thrust}), 18'sd0, cfg.ramp_down_step);
	assign slew_noz = move_toward(18'(signed'(cur.nozzle)), commanded, cfg.deflection_step);

	// next state of the thruster
	always_comb begin
		nxt.nozzle = slew_noz[15:0];
		if (demand == 16'd0) begin
			nxt.lit     = 1'b0;
			nxt.ign_cnt = 16'd0;
			nxt.thrust  = slew_dn[15:0];
		end else if (lit_now) begin
			nxt.lit     = 1'b1;
			nxt.ign_cnt = 16'd0;
			nxt.thrust  = (slew_up[15:0] < floor_v) ? floor_v : slew_up[15:0];
		end else begin
			nxt.lit     = 1'b0;
			nxt.ign_cnt = cd_load - 16'd1;
			nxt.thrust  = cur.thrust;
		end
	end

endmodule
